// ===== rtl/p2t_pkg.sv =====
// ----------------------------------------------------------------------------
// p2t_pkg
// Shared types and constant tables for the prism to tetrahedra splitter:
// corner rotation table and the two tetrahedron corner lists.
// ----------------------------------------------------------------------------
package p2t_pkg;

  // Global vertex index
  typedef logic [31:0] vidx_t;

  // Corner position within a prism, 0..5
  typedef logic [2:0] corner_t;

  // Tetrahedron position within a prism, 0..2
  typedef logic [1:0] tet_pos_t;

  localparam int unsigned NUM_CORNERS = 6;
  localparam int unsigned NUM_TETS    = 3;
  localparam int unsigned TET_CORNERS = 4;

  localparam tet_pos_t TET_FIRST = 2'd0;
  localparam tet_pos_t TET_LAST  = 2'd2;

  // Rotated corner k takes original corner ROT_TABLE[min_pos][k]
  localparam corner_t ROT_TABLE [NUM_CORNERS][NUM_CORNERS] = '{
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5},
    '{3'd1, 3'd2, 3'd0, 3'd4, 3'd5, 3'd3},
    '{3'd2, 3'd0, 3'd1, 3'd5, 3'd3, 3'd4},
    '{3'd3, 3'd5, 3'd4, 3'd0, 3'd2, 3'd1},
    '{3'd4, 3'd3, 3'd5, 3'd1, 3'd0, 3'd2},
    '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0}
  };

  // Tetrahedra for diagonal 2-6, in rotated corner numbers
  localparam corner_t TETS_26 [NUM_TETS][TET_CORNERS] = '{
    '{3'd0, 3'd1, 3'd2, 3'd5},
    '{3'd0, 3'd1, 3'd5, 3'd4},
    '{3'd0, 3'd4, 3'd5, 3'd3}
  };

  // Tetrahedra for diagonal 3-5, in rotated corner numbers
  localparam corner_t TETS_35 [NUM_TETS][TET_CORNERS] = '{
    '{3'd0, 3'd1, 3'd2, 3'd4},
    '{3'd0, 3'd4, 3'd2, 3'd5},
    '{3'd0, 3'd4, 3'd5, 3'd3}
  };

  // Minimum candidate: value and the corner it came from
  typedef struct packed {
    vidx_t   val;
    corner_t pos;
  } cand_t;

endpackage

// ===== rtl/prism_to_tetra_split.sv =====
// ----------------------------------------------------------------------------
// prism_to_tetra_split
// Splits one triangular prism, given as six global vertex indices, into
// three tetrahedra emitted one per cycle.
// ----------------------------------------------------------------------------
// Usage: present the six corner indices with start high; the item is taken
// at a clock edge where busy is low. Each item produces three results, one
// per cycle, each shown for exactly one cycle with out_strobe high; the
// receiver cannot stall them. The emitter sends one tetrahedron per cycle,
// and busy goes high after each accepted item to hold off the next one; a
// new item is still taken before the last one has left the pipeline. Each
// item passes through pairwise minimum, minimum merge, rotation, diagonal
// select and emit, and successive items overlap in the pipeline.
// ----------------------------------------------------------------------------
module prism_to_tetra_split
  import p2t_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  vidx_t    in_vertex_one,
  input  vidx_t    in_vertex_two,
  input  vidx_t    in_vertex_three,
  input  vidx_t    in_vertex_four,
  input  vidx_t    in_vertex_five,
  input  vidx_t    in_vertex_six,
  output logic     out_strobe,
  output vidx_t    out_tet_corner_a,
  output vidx_t    out_tet_corner_b,
  output vidx_t    out_tet_corner_c,
  output vidx_t    out_tet_corner_d,
  output tet_pos_t out_tet_position,
  output logic     out_last_of_prism
);

  logic accept;
  assign accept = start && !busy;

  // Input throttle: hold off new items while the countdown started by each accepted item runs
  logic [1:0] gap_r, gap_nxt;
  always_comb begin
    if (accept) begin
      gap_nxt = 2'd2;
    end else if (gap_r != 2'd0) begin
      gap_nxt = gap_r - 2'd1;
    end else begin
      gap_nxt = gap_r;
    end
  end
  assign busy = (gap_r != 2'd0);

  // Stage A: capture corners and pairwise minimum, first position wins ties
  logic  a_valid_r;
  vidx_t a_v_r [NUM_CORNERS];
  cand_t a_m01_r, a_m23_r, a_m45_r;
  cand_t a_m01_nxt, a_m23_nxt, a_m45_nxt;

  always_comb begin
    a_m01_nxt = (in_vertex_two < in_vertex_one) ? cand_t'{in_vertex_two, 3'd1}
                                                : cand_t'{in_vertex_one, 3'd0};
    a_m23_nxt = (in_vertex_four < in_vertex_three) ? cand_t'{in_vertex_four, 3'd3}
                                                   : cand_t'{in_vertex_three, 3'd2};
    a_m45_nxt = (in_vertex_six < in_vertex_five) ? cand_t'{in_vertex_six, 3'd5}
                                                 : cand_t'{in_vertex_five, 3'd4};
  end

  // Stage B: merge first two pairs
  logic  b_valid_r;
  vidx_t b_v_r [NUM_CORNERS];
  cand_t b_m03_r, b_m45_r;
  cand_t b_m03_nxt;
  assign b_m03_nxt = (a_m23_r.val < a_m01_r.val) ? a_m23_r : a_m01_r;

  // Stage C: final minimum and rotation
  logic    c_valid_r;
  vidx_t   c_r_r [NUM_CORNERS];
  corner_t c_pos;
  vidx_t   c_r_nxt [NUM_CORNERS];
  assign c_pos = (b_m45_r.val < b_m03_r.val) ? b_m45_r.pos : b_m03_r.pos;
  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      c_r_nxt[k] = b_v_r[ROT_TABLE[c_pos][k]];
    end
  end

  // Stage D: diagonal choice on rotated corners 2, 6, 3, 5
  logic  d_valid_r;
  vidx_t d_r_r [NUM_CORNERS];
  logic  d_diag35_r, d_diag35_nxt;
  always_comb begin
    vidx_t best;
    best         = c_r_r[1];
    d_diag35_nxt = 1'b0;
    if (c_r_r[5] < best) begin
      best = c_r_r[5];
    end
    if (c_r_r[2] < best) begin
      best         = c_r_r[2];
      d_diag35_nxt = 1'b1;
    end
    if (c_r_r[4] < best) begin
      d_diag35_nxt = 1'b1;
    end
  end

  // Emitter: one tetrahedron per cycle from the held prism
  logic     e_act_r;
  tet_pos_t e_cnt_r;
  vidx_t    e_r_r [NUM_CORNERS];
  logic     e_diag35_r;
  corner_t  e_sel [TET_CORNERS];
  always_comb begin
    for (int i = 0; i < TET_CORNERS; i++) begin
      e_sel[i] = e_diag35_r ? TETS_35[e_cnt_r][i] : TETS_26[e_cnt_r][i];
    end
  end

  logic     out_strobe_r;
  vidx_t    out_a_r, out_b_r, out_c_r, out_d_r;
  tet_pos_t out_pos_r;
  logic     out_last_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r        <= 2'd0;
      a_valid_r    <= 1'b0;
      b_valid_r    <= 1'b0;
      c_valid_r    <= 1'b0;
      d_valid_r    <= 1'b0;
      e_act_r      <= 1'b0;
      e_cnt_r      <= TET_FIRST;
      out_strobe_r <= 1'b0;
    end else begin
      gap_r        <= gap_nxt;
      a_valid_r    <= accept;
      b_valid_r    <= a_valid_r;
      c_valid_r    <= b_valid_r;
      d_valid_r    <= c_valid_r;
      out_strobe_r <= e_act_r;
      if (d_valid_r) begin
        e_act_r <= 1'b1;
        e_cnt_r <= TET_FIRST;
      end else if (e_act_r) begin
        // hold the count on the last tetrahedron so it stays in the table
        if (e_cnt_r == TET_LAST) begin
          e_act_r <= 1'b0;
        end else begin
          e_cnt_r <= e_cnt_r + 2'd1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    a_v_r[0] <= in_vertex_one;
    a_v_r[1] <= in_vertex_two;
    a_v_r[2] <= in_vertex_three;
    a_v_r[3] <= in_vertex_four;
    a_v_r[4] <= in_vertex_five;
    a_v_r[5] <= in_vertex_six;
    a_m01_r  <= a_m01_nxt;
    a_m23_r  <= a_m23_nxt;
    a_m45_r  <= a_m45_nxt;
    b_v_r    <= a_v_r;
    b_m03_r  <= b_m03_nxt;
    b_m45_r  <= a_m45_r;
    c_r_r    <= c_r_nxt;
    d_r_r    <= c_r_r;
    d_diag35_r <= d_diag35_nxt;
    if (d_valid_r) begin
      e_r_r      <= d_r_r;
      e_diag35_r <= d_diag35_r;
    end
    out_a_r    <= e_r_r[e_sel[0]];
    out_b_r    <= e_r_r[e_sel[1]];
    out_c_r    <= e_r_r[e_sel[2]];
    out_d_r    <= e_r_r[e_sel[3]];
    out_pos_r  <= e_cnt_r;
    out_last_r <= (e_cnt_r == TET_LAST);
  end

  assign out_strobe        = out_strobe_r;
  assign out_tet_corner_a  = out_a_r;
  assign out_tet_corner_b  = out_b_r;
  assign out_tet_corner_c  = out_c_r;
  assign out_tet_corner_d  = out_d_r;
  assign out_tet_position  = out_pos_r;
  assign out_last_of_prism = out_last_r;

`ifndef SYNTH
  // Accepted item blocks the input for the next cycle
  a_throttle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("input accepted without throttle");

  // A new prism reaches the emitter only as the previous one finishes
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (d_valid_r && e_act_r) |-> (e_cnt_r == TET_LAST))
    else $error("emitter overrun");

  // Last flag only on the third tetrahedron
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_last_of_prism == (out_tet_position == TET_LAST)))
    else $error("last flag mismatch");

  // Later tetrahedra follow their predecessor directly
  a_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_tet_position != TET_FIRST)) |->
      ($past(out_strobe) && ($past(out_tet_position) + 2'd1 == out_tet_position)))
    else $error("tetrahedron sequence broken");
`endif

endmodule
